// File: design/vertex_rotate_project_defines.svh
// Assertion macros shared by the files that check the vertex pipeline.
`ifndef VERTEX_ROTATE_PROJECT_DEFINES_SVH
`define VERTEX_ROTATE_PROJECT_DEFINES_SVH

// Same-cycle implication, sampled on clk and masked during rst.
`define VRP_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vertex_rotate_project: check failed");

// Implication after a fixed number of cycles.
`define VRP_CHECK_DLY(label, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(dly) (cons)) \
    else $error("vertex_rotate_project: timing check failed");

`endif

// File: design/vrp_pkg.sv
package vrp_pkg;

  // Field and datapath widths
  localparam int VW    = 16;          // vertex coordinate
  localparam int CW    = 10;          // 2.8 trig coefficient
  localparam int FRAC  = 8;           // fraction bits of the coefficients
  localparam int PW    = VW + CW;     // first rotation products
  localparam int RW    = 20;          // rotated x, y, z
  localparam int QPW   = RW + CW;     // second rotation products
  localparam int DPW   = 22;          // full view depth
  localparam int NW    = 28;          // coordinate times focal length
  localparam int MW    = NW - 1;      // magnitude of the above
  localparam int DUW   = DPW - 1;     // divisor, depth known positive
  localparam int QW    = 11;          // quotient bits kept
  localparam int REMW  = DUW + QW;    // partial remainder
  localparam int VDW   = 16;          // reported depth
  localparam int SXW   = 11;
  localparam int SYW   = 10;
  localparam int PXW   = 13;          // projected point before window test
  localparam int IDXW  = 3;
  localparam int LANES = 2;
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;

  // Stage counts from accept to result strobe
  localparam int ROT_STAGES  = 4;
  localparam int PREP_STAGES = 3;
  localparam int LATENCY     = ROT_STAGES + PREP_STAGES + QW + 1;

  // Register indexes
  localparam logic [IDXW-1:0] REG_COS_YAW   = 3'd0;
  localparam logic [IDXW-1:0] REG_SIN_YAW   = 3'd1;
  localparam logic [IDXW-1:0] REG_COS_PITCH = 3'd2;
  localparam logic [IDXW-1:0] REG_SIN_PITCH = 3'd3;
  localparam logic [IDXW-1:0] REG_CAM_DIST  = 3'd4;

  // Register reset values
  localparam logic signed [CW-1:0] COS_RESET  = 10'sd256;
  localparam logic signed [CW-1:0] SIN_RESET  = 10'sd0;
  localparam logic signed [VW-1:0] DIST_RESET = 16'sd200;

  // Projection constants
  localparam logic signed [DPW-1:0] NEAR_LIMIT = 22'sd24;
  localparam logic signed [NW-1:0]  FOCAL      = 28'sd160;
  localparam logic signed [PXW-1:0] CENTRE_X   = 13'sd128;
  localparam logic signed [PXW-1:0] CENTRE_Y   = 13'sd80;
  localparam logic signed [PXW-1:0] GUARD_LO   = -13'sd320;
  localparam logic signed [PXW-1:0] GUARD_X_HI = 13'sd640;
  localparam logic signed [PXW-1:0] GUARD_Y_HI = 13'sd480;

  typedef struct packed {
    logic signed [CW-1:0] cos_yaw;
    logic signed [CW-1:0] sin_yaw;
    logic signed [CW-1:0] cos_pitch;
    logic signed [CW-1:0] sin_pitch;
    logic signed [VW-1:0] camera_distance;
  } coef_t;

  typedef struct packed {
    logic                  valid;
    logic signed [RW-1:0]  rx;
    logic signed [RW-1:0]  ry;
    logic signed [DPW-1:0] depth;
  } rot_t;

  // One divider stage: both lanes share the divisor
  typedef struct packed {
    logic                             valid;
    logic                             near;
    logic [VDW-1:0]                   view_depth;
    logic [DUW-1:0]                   divisor;
    logic [LANES-1:0]                 neg;
    logic [LANES-1:0]                 ovf;
    logic [LANES-1:0][REMW-1:0]       rem;
    logic [LANES-1:0][QW-1:0]         quo;
  } div_t;

endpackage

// File: design/vertex_rotate_project.sv
// Vertex rotate and project.
//
// Input: pulse start with vertex_x/y/z while busy is low and the vertex is
// taken at that edge. A new vertex may follow in every cycle, so the block
// sustains one vertex per clock.
// Output: done is high for exactly one cycle per vertex with visible,
// screen_x, screen_y and view_depth valid alongside it. Results leave in
// the order vertices entered, after four rotation stages, three scaling
// stages, eleven divider stages (one quotient bit each, set by the
// bit-per-stage divider) and the output register. The receiver cannot
// stall; results are never held back.
// Configuration: write register index cfg_index with cfg_data when
// cfg_valid and cfg_ready are both high. Write only while no vertex is in
// flight; unknown indexes are ignored.
// Reset (rst, synchronous): restores yaw and pitch to zero angle and the
// camera distance to 200, and empties the pipeline. busy is high and
// cfg_ready low only while rst is held.
`include "vertex_rotate_project_defines.svh"

module vertex_rotate_project (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [vrp_pkg::VW-1:0]        vertex_x,
  input  logic signed [vrp_pkg::VW-1:0]        vertex_y,
  input  logic signed [vrp_pkg::VW-1:0]        vertex_z,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [vrp_pkg::IDXW-1:0]             cfg_index,
  input  logic [vrp_pkg::VW-1:0]               cfg_data,
  output logic                                 done,
  output logic                                 visible,
  output logic signed [vrp_pkg::SXW-1:0]       screen_x,
  output logic signed [vrp_pkg::SYW-1:0]       screen_y,
  output logic signed [vrp_pkg::VDW-1:0]       view_depth
);

  vrp_pkg::coef_t coef;
  vrp_pkg::rot_t  rot;
  vrp_pkg::div_t  dv_pre;
  vrp_pkg::div_t  dv_post;

  logic signed [vrp_pkg::PXW-1:0] qx, qy, px, py;
  logic                           in_win, vis;

  // Only reset holds off vertices and register writes
  assign busy      = rst;
  assign cfg_ready = !rst;

  // Configuration registers; keep the low bits of each write
  always_ff @(posedge clk) begin
    if (rst) begin
      coef.cos_yaw         <= vrp_pkg::COS_RESET;
      coef.sin_yaw         <= vrp_pkg::SIN_RESET;
      coef.cos_pitch       <= vrp_pkg::COS_RESET;
      coef.sin_pitch       <= vrp_pkg::SIN_RESET;
      coef.camera_distance <= vrp_pkg::DIST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vrp_pkg::REG_COS_YAW:   coef.cos_yaw         <= cfg_data[vrp_pkg::CW-1:0];
        vrp_pkg::REG_SIN_YAW:   coef.sin_yaw         <= cfg_data[vrp_pkg::CW-1:0];
        vrp_pkg::REG_COS_PITCH: coef.cos_pitch       <= cfg_data[vrp_pkg::CW-1:0];
        vrp_pkg::REG_SIN_PITCH: coef.sin_pitch       <= cfg_data[vrp_pkg::CW-1:0];
        vrp_pkg::REG_CAM_DIST:  coef.camera_distance <= cfg_data;
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

  // Yaw then pitch rotation, plus camera distance
  vrp_rotate u_rotate (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .vx       (vertex_x),
    .vy       (vertex_y),
    .vz       (vertex_z),
    .coef     (coef),
    .rot      (rot)
  );

  // Focal scaling, near test, sign split and quotient range check
  vrp_prep u_prep (
    .clk (clk),
    .rst (rst),
    .rot (rot),
    .dv  (dv_pre)
  );

  // Both coordinates divided by depth side by side
  vrp_div u_div (
    .clk    (clk),
    .rst    (rst),
    .dv_in  (dv_pre),
    .dv_out (dv_post)
  );

  // Re-apply the sign (truncation toward zero) and offset about the centre
  always_comb begin
    qx = vrp_pkg::PXW'(dv_post.quo[vrp_pkg::LANE_X]);
    qy = vrp_pkg::PXW'(dv_post.quo[vrp_pkg::LANE_Y]);
    px = dv_post.neg[vrp_pkg::LANE_X] ? vrp_pkg::CENTRE_X - qx : vrp_pkg::CENTRE_X + qx;
    py = dv_post.neg[vrp_pkg::LANE_Y] ? vrp_pkg::CENTRE_Y + qy : vrp_pkg::CENTRE_Y - qy;
    in_win = (px >= vrp_pkg::GUARD_LO) && (px <= vrp_pkg::GUARD_X_HI)
          && (py >= vrp_pkg::GUARD_LO) && (py <= vrp_pkg::GUARD_Y_HI);
    // An oversize quotient is already outside the guard window
    vis = !dv_post.near && (dv_post.ovf == '0) && in_win;
  end

  // Result register; zero the screen point of a hidden vertex
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_post.valid;
    end
  end

  always_ff @(posedge clk) begin
    visible    <= vis;
    screen_x   <= vis ? vrp_pkg::SXW'(px) : '0;
    screen_y   <= vis ? vrp_pkg::SYW'(py) : '0;
    view_depth <= dv_post.view_depth;
  end

  // Checks
  `VRP_CHECK(a_hidden_zero, done && !visible, screen_x == '0 && screen_y == '0)
  `VRP_CHECK_DLY(a_latency, start && !busy, vrp_pkg::LATENCY, done)
  `VRP_CHECK(a_window_x, done && visible, screen_x >= vrp_pkg::GUARD_LO && screen_x <= vrp_pkg::GUARD_X_HI)

endmodule

// File: design/vrp_rotate.sv
module vrp_rotate (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic signed [vrp_pkg::VW-1:0] vx,
  input  logic signed [vrp_pkg::VW-1:0] vy,
  input  logic signed [vrp_pkg::VW-1:0] vz,
  input  vrp_pkg::coef_t              coef,
  output vrp_pkg::rot_t               rot
);

  logic v1, v2, v3;

  logic signed [vrp_pkg::PW-1:0]  p_xc, p_zs, p_zc, p_xs;
  logic signed [vrp_pkg::VW-1:0]  vy1, vy2;
  logic signed [vrp_pkg::PW:0]    s_x, s_z;
  logic signed [vrp_pkg::RW-1:0]  rx2, rz2, rx3;
  logic signed [vrp_pkg::QPW-1:0] q_yc, q_zs, q_ys, q_zc;
  logic signed [vrp_pkg::QPW:0]   d_y, d_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Yaw products
  always_ff @(posedge clk) begin
    p_xc <= vrp_pkg::PW'(vx) * vrp_pkg::PW'(coef.cos_yaw);
    p_zs <= vrp_pkg::PW'(vz) * vrp_pkg::PW'(coef.sin_yaw);
    p_zc <= vrp_pkg::PW'(vz) * vrp_pkg::PW'(coef.cos_yaw);
    p_xs <= vrp_pkg::PW'(vx) * vrp_pkg::PW'(coef.sin_yaw);
    vy1  <= vy;
  end

  always_comb begin
    s_x = (vrp_pkg::PW+1)'(p_xc) + (vrp_pkg::PW+1)'(p_zs);
    s_z = (vrp_pkg::PW+1)'(p_zc) - (vrp_pkg::PW+1)'(p_xs);
  end

  always_ff @(posedge clk) begin
    rx2 <= vrp_pkg::RW'(s_x >>> vrp_pkg::FRAC);
    rz2 <= vrp_pkg::RW'(s_z >>> vrp_pkg::FRAC);
    vy2 <= vy1;
  end

  // Pitch products
  always_ff @(posedge clk) begin
    q_yc <= vrp_pkg::QPW'(vy2) * vrp_pkg::QPW'(coef.cos_pitch);
    q_zs <= vrp_pkg::QPW'(rz2) * vrp_pkg::QPW'(coef.sin_pitch);
    q_ys <= vrp_pkg::QPW'(vy2) * vrp_pkg::QPW'(coef.sin_pitch);
    q_zc <= vrp_pkg::QPW'(rz2) * vrp_pkg::QPW'(coef.cos_pitch);
    rx3  <= rx2;
  end

  always_comb begin
    d_y = (vrp_pkg::QPW+1)'(q_yc) - (vrp_pkg::QPW+1)'(q_zs);
    d_z = (vrp_pkg::QPW+1)'(q_ys) + (vrp_pkg::QPW+1)'(q_zc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rot.valid <= 1'b0;
    end else begin
      rot.valid <= v3;
    end
    rot.rx    <= rx3;
    rot.ry    <= vrp_pkg::RW'(d_y >>> vrp_pkg::FRAC);
    rot.depth <= vrp_pkg::DPW'(d_z >>> vrp_pkg::FRAC)
               + vrp_pkg::DPW'(coef.camera_distance);
  end

endmodule

// File: design/vrp_prep.sv
module vrp_prep (
  input  logic          clk,
  input  logic          rst,
  input  vrp_pkg::rot_t rot,
  output vrp_pkg::div_t dv
);

  logic v5, v6;

  logic signed [vrp_pkg::NW-1:0]  nx5, ny5;
  logic signed [vrp_pkg::DPW-1:0] depth5;
  logic                           near5, near6;
  logic [vrp_pkg::LANES-1:0][vrp_pkg::MW-1:0] mag6;
  logic [vrp_pkg::LANES-1:0]      neg6;
  logic [vrp_pkg::DUW-1:0]        div6;
  logic [vrp_pkg::VDW-1:0]        vd6;
  logic [vrp_pkg::REMW-1:0]       dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      v5 <= rot.valid;
      v6 <= v5;
    end
  end

  // Scale by focal length, flag near points
  always_ff @(posedge clk) begin
    nx5    <= vrp_pkg::NW'(rot.rx) * vrp_pkg::FOCAL;
    ny5    <= vrp_pkg::NW'(rot.ry) * vrp_pkg::FOCAL;
    near5  <= rot.depth < vrp_pkg::NEAR_LIMIT;
    depth5 <= rot.depth;
  end

  // Split into sign and magnitude
  always_ff @(posedge clk) begin
    mag6[vrp_pkg::LANE_X] <= vrp_pkg::MW'(nx5[vrp_pkg::NW-1] ? -nx5 : nx5);
    mag6[vrp_pkg::LANE_Y] <= vrp_pkg::MW'(ny5[vrp_pkg::NW-1] ? -ny5 : ny5);
    neg6[vrp_pkg::LANE_X] <= nx5[vrp_pkg::NW-1];
    neg6[vrp_pkg::LANE_Y] <= ny5[vrp_pkg::NW-1];
    near6 <= near5;
    div6  <= depth5[vrp_pkg::DUW-1:0];
    vd6   <= depth5[vrp_pkg::VDW-1:0];
  end

  // Quotients of 2^QW or more always land outside the window
  assign dsh = {div6, {vrp_pkg::QW{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      dv.valid <= 1'b0;
    end else begin
      dv.valid <= v6;
    end
    dv.near       <= near6;
    dv.view_depth <= vd6;
    dv.divisor    <= div6;
    dv.neg        <= neg6;
    dv.quo        <= '0;
    for (int l = 0; l < vrp_pkg::LANES; l++) begin
      dv.ovf[l] <= vrp_pkg::REMW'(mag6[l]) >= dsh;
      dv.rem[l] <= vrp_pkg::REMW'(mag6[l]);
    end
  end

endmodule

// File: design/vrp_div.sv
module vrp_div (
  input  logic          clk,
  input  logic          rst,
  input  vrp_pkg::div_t dv_in,
  output vrp_pkg::div_t dv_out
);

  vrp_pkg::div_t st [vrp_pkg::QW];

  // One restoring step per stage, most significant quotient bit first
  for (genvar k = 0; k < vrp_pkg::QW; k++) begin : g_step
    vrp_pkg::div_t            src;
    vrp_pkg::div_t            res;
    logic [vrp_pkg::REMW-1:0] dsh;

    if (k == 0) begin : g_first
      assign src = dv_in;
    end else begin : g_next
      assign src = st[k-1];
    end

    always_comb begin
      res = src;
      dsh = vrp_pkg::REMW'(src.divisor) << (vrp_pkg::QW - 1 - k);
      for (int l = 0; l < vrp_pkg::LANES; l++) begin
        if (src.rem[l] >= dsh) begin
          res.rem[l] = src.rem[l] - dsh;
          res.quo[l][vrp_pkg::QW-1-k] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st[k] <= '0;
      end else begin
        st[k] <= res;
      end
    end
  end

  assign dv_out = st[vrp_pkg::QW-1];

endmodule

// File: sim/vertex_rotate_project_test.sv
// Predicts one projection per vertex and holds the projections still owed by the pipeline.
class projection_board;

  typedef struct {
    logic                              visible;
    logic signed [vrp_pkg::SXW-1:0]    screen_x;
    logic signed [vrp_pkg::SYW-1:0]    screen_y;
    logic signed [vrp_pkg::VDW-1:0]    view_depth;
  } projection_t;

  localparam longint NEAR_DEPTH = 24;
  localparam longint FOCAL_LEN  = 160;
  localparam longint MID_X      = 128;
  localparam longint MID_Y      = 80;
  localparam longint WIN_LO     = -320;
  localparam longint WIN_X_HI   = 640;
  localparam longint WIN_Y_HI   = 480;
  localparam int     SHOWN      = 10;

  logic signed [vrp_pkg::CW-1:0] cos_yaw;
  logic signed [vrp_pkg::CW-1:0] sin_yaw;
  logic signed [vrp_pkg::CW-1:0] cos_pitch;
  logic signed [vrp_pkg::CW-1:0] sin_pitch;
  logic signed [vrp_pkg::VW-1:0] camera_distance;

  projection_t owed_projections[$];
  int unsigned mismatches;

  function new();
    mismatches = 0;
    restore();
  endfunction

  function void restore();
    cos_yaw         = vrp_pkg::COS_RESET;
    sin_yaw         = vrp_pkg::SIN_RESET;
    cos_pitch       = vrp_pkg::COS_RESET;
    sin_pitch       = vrp_pkg::SIN_RESET;
    camera_distance = vrp_pkg::DIST_RESET;
    owed_projections.delete();
  endfunction

  // Coefficients keep only their low bits; unknown indexes change nothing.
  function void set_register(logic [vrp_pkg::IDXW-1:0] index, logic [vrp_pkg::VW-1:0] data);
    case (index)
      vrp_pkg::REG_COS_YAW:   cos_yaw   = data[vrp_pkg::CW-1:0];
      vrp_pkg::REG_SIN_YAW:   sin_yaw   = data[vrp_pkg::CW-1:0];
      vrp_pkg::REG_COS_PITCH: cos_pitch = data[vrp_pkg::CW-1:0];
      vrp_pkg::REG_SIN_PITCH: sin_pitch = data[vrp_pkg::CW-1:0];
      vrp_pkg::REG_CAM_DIST:  camera_distance = data;
      default: ;
    endcase
  endfunction

  function void note_vertex(logic signed [vrp_pkg::VW-1:0] x,
                            logic signed [vrp_pkg::VW-1:0] y,
                            logic signed [vrp_pkg::VW-1:0] z);
    longint vx, vy, vz, rx, ry, rz, depth, px, py;
    projection_t p;
    vx = x;
    vy = y;
    vz = z;
    rx = (vx * cos_yaw + vz * sin_yaw) >>> vrp_pkg::FRAC;
    rz = (vz * cos_yaw - vx * sin_yaw) >>> vrp_pkg::FRAC;
    ry = (vy * cos_pitch - rz * sin_pitch) >>> vrp_pkg::FRAC;
    depth = ((vy * sin_pitch + rz * cos_pitch) >>> vrp_pkg::FRAC) + camera_distance;
    p.visible    = 1'b0;
    p.screen_x   = '0;
    p.screen_y   = '0;
    p.view_depth = depth[vrp_pkg::VDW-1:0];
    if (depth >= NEAR_DEPTH) begin
      px = MID_X + (rx * FOCAL_LEN) / depth;
      py = MID_Y - (ry * FOCAL_LEN) / depth;
      if (px >= WIN_LO && px <= WIN_X_HI && py >= WIN_LO && py <= WIN_Y_HI) begin
        p.visible  = 1'b1;
        p.screen_x = px[vrp_pkg::SXW-1:0];
        p.screen_y = py[vrp_pkg::SYW-1:0];
      end
    end
    owed_projections.push_back(p);
  endfunction

  function void check_projection(logic                           visible,
                                 logic signed [vrp_pkg::SXW-1:0] screen_x,
                                 logic signed [vrp_pkg::SYW-1:0] screen_y,
                                 logic signed [vrp_pkg::VDW-1:0] view_depth);
    projection_t want;
    if (owed_projections.size() == 0) begin
      mismatches++;
      if (mismatches <= SHOWN)
        $display("unexpected projection: visible=%0d x=%0d y=%0d depth=%0d",
                 visible, screen_x, screen_y, view_depth);
      return;
    end
    want = owed_projections.pop_front();
    if (visible !== want.visible || screen_x !== want.screen_x ||
        screen_y !== want.screen_y || view_depth !== want.view_depth) begin
      mismatches++;
      if (mismatches <= SHOWN)
        $display("projection mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                 want.visible, want.screen_x, want.screen_y, want.view_depth,
                 visible, screen_x, screen_y, view_depth);
    end
  endfunction

  function int unsigned outstanding();
    return owed_projections.size();
  endfunction

endclass

module vertex_rotate_project_test;

  localparam int  RESET_CYCLES   = 10;
  localparam int  WATCHDOG_LIMIT = 1000;
  localparam int  PHASES         = 14;
  localparam int  PHASE_ITEMS    = 140;
  localparam int  CALM_PHASES    = 2;     // closing phases run back to back
  localparam int  BURST_MAX      = 19;
  localparam real DEG            = 3.14159265358979 / 180.0;

  // Highest register index; everything above the camera distance is unused.
  localparam logic [vrp_pkg::IDXW-1:0] REG_SPARE_TOP = '1;

  logic                           clk        = 1'b0;
  logic                           rst        = 1'b1;
  logic                           start      = 1'b0;
  logic signed [vrp_pkg::VW-1:0]  vertex_x   = '0;
  logic signed [vrp_pkg::VW-1:0]  vertex_y   = '0;
  logic signed [vrp_pkg::VW-1:0]  vertex_z   = '0;
  logic                           cfg_valid  = 1'b0;
  logic [vrp_pkg::IDXW-1:0]       cfg_index  = '0;
  logic [vrp_pkg::VW-1:0]         cfg_data   = '0;
  logic                           busy;
  logic                           cfg_ready;
  logic                           done;
  logic                           visible;
  logic signed [vrp_pkg::SXW-1:0] screen_x;
  logic signed [vrp_pkg::SYW-1:0] screen_y;
  logic signed [vrp_pkg::VDW-1:0] view_depth;

  int unsigned     quiet_cycles = 0;
  projection_board projections;

  always #5 clk = ~clk;

  vertex_rotate_project u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .vertex_x   (vertex_x),
    .vertex_y   (vertex_y),
    .vertex_z   (vertex_z),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .done       (done),
    .visible    (visible),
    .screen_x   (screen_x),
    .screen_y   (screen_y),
    .view_depth (view_depth)
  );

  // Take every strobed result at the edge that closes its cycle; an unknown
  // strobe counts as a result so that it cannot slip past unchecked.
  always @(posedge clk) begin
    if (!rst && done !== 1'b0)
      projections.check_projection(visible, screen_x, screen_y, view_depth);
  end

  // Count cycles in which no item, result or register write moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("vertex_rotate_project_test NOT OK");
    $finish;
  end

  // Present one vertex and hold start high until the block takes it; leave
  // start raised so that the next item can follow in the very next cycle.
  task automatic send_vertex(input logic signed [vrp_pkg::VW-1:0] x,
                             input logic signed [vrp_pkg::VW-1:0] y,
                             input logic signed [vrp_pkg::VW-1:0] z);
    start    <= 1'b1;
    vertex_x <= x;
    vertex_y <= y;
    vertex_z <= z;
    do @(posedge clk); while (busy !== 1'b0);
    projections.note_vertex(x, y, z);
  endtask

  task automatic hold_off(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drop start and wait for the pipeline to hand back every owed projection.
  task automatic drain_pipeline();
    start <= 1'b0;
    while (projections.outstanding() != 0) @(posedge clk);
  endtask

  // Leave cfg_valid high; the caller drops it once after the last write.
  task automatic write_register(input logic [vrp_pkg::IDXW-1:0] index,
                                input logic [vrp_pkg::VW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    projections.set_register(index, data);
  endtask

  // Fill the unused upper bits of a coefficient word with noise.
  function automatic logic [vrp_pkg::VW-1:0] coef_word(input int value);
    logic [vrp_pkg::VW-1:0] noise;
    noise = vrp_pkg::VW'($urandom());
    return {noise[vrp_pkg::VW-1:vrp_pkg::CW], value[vrp_pkg::CW-1:0]};
  endfunction

  function automatic logic signed [vrp_pkg::VW-1:0] pick_coord(input int unsigned span);
    int v;
    if (span == 0)
      v = $urandom();
    else
      v = int'($urandom_range(2 * span, 0)) - int'(span);
    return v[vrp_pkg::VW-1:0];
  endfunction

  // Load one register setting: the first few are the corners of the
  // coefficient range, then real angles, with every third one pure noise.
  task automatic load_setting(input int phase);
    int  cy, sy, cp, sp, cam;
    real yaw, pitch;
    case (phase)
      0: begin
        cy = 256;  sy = 256;  cp = 256;  sp = 256;  cam = 32767;
      end
      1: begin
        cy = -256; sy = -256; cp = -256; sp = -256; cam = -32768;
      end
      2: begin
        // beyond +-256, taken as plain 10-bit signed values
        cy = 511;  sy = -512; cp = -512; sp = 511;  cam = 24;
      end
      3: begin
        cy = -256; sy = 0;    cp = 0;    sp = -256; cam = 0;
      end
      default: begin
        if (phase % 3 == 2) begin
          cy  = $urandom();
          sy  = $urandom();
          cp  = $urandom();
          sp  = $urandom();
          cam = $urandom();
        end else begin
          yaw   = $urandom_range(359, 0) * DEG;
          pitch = $urandom_range(359, 0) * DEG;
          cy  = $rtoi($floor($cos(yaw) * 256.0 + 0.5));
          sy  = $rtoi($floor($sin(yaw) * 256.0 + 0.5));
          cp  = $rtoi($floor($cos(pitch) * 256.0 + 0.5));
          sp  = $rtoi($floor($sin(pitch) * 256.0 + 0.5));
          cam = $urandom_range(1500, 40);
        end
      end
    endcase
    // An unused index must leave the setting untouched.
    write_register(vrp_pkg::IDXW'($urandom_range(REG_SPARE_TOP, vrp_pkg::REG_CAM_DIST + 1)),
                   vrp_pkg::VW'($urandom()));
    write_register(vrp_pkg::REG_COS_YAW, coef_word(cy));
    write_register(vrp_pkg::REG_SIN_YAW, coef_word(sy));
    write_register(vrp_pkg::REG_COS_PITCH, coef_word(cp));
    write_register(vrp_pkg::REG_SIN_PITCH, coef_word(sp));
    write_register(vrp_pkg::REG_CAM_DIST, cam[vrp_pkg::VW-1:0]);
    cfg_valid <= 1'b0;
  endtask

  // Random vertices: mostly small ones that land on screen, some mid-sized,
  // some across the full range. Idle in bursts, with calm stretches between.
  task automatic run_vertices(input int unsigned items, input bit idling);
    int unsigned span;
    bit          calm;
    calm = 1'b1;
    for (int unsigned i = 0; i < items; i++) begin
      if (i % 32 == 0)
        calm = !idling || ($urandom_range(3, 0) == 0);
      if (!calm && $urandom_range(5, 0) == 0)
        hold_off($urandom_range(BURST_MAX, 1));
      case ($urandom_range(3, 0))
        0:       span = 0;
        1, 2:    span = 700;
        default: span = 5000;
      endcase
      send_vertex(pick_coord(span), pick_coord(span), pick_coord(span));
    end
  endtask

  initial begin
    projections = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset setting is the identity rotation at distance 200, so the screen
    // point is simply centre plus 0.8 times x and minus 0.8 times y.
    send_vertex(0, 0, 0);
    send_vertex(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_vertex(-16'sh8000, -16'sh8000, -16'sh8000);
    send_vertex(16'sh7fff, -16'sh8000, 0);
    send_vertex(-16'sh8000, 16'sh7fff, -1);
    send_vertex(0, 0, 16'sh7fff);      // depth past 16 bits, reported wrapped
    send_vertex(0, 0, -16'sh8000);
    send_vertex(0, 0, -177);           // one short of the near limit
    send_vertex(0, 0, -176);           // exactly on the near limit
    send_vertex(-1, 1, 0);             // quotients round toward zero
    send_vertex(640, 0, 0);            // right edge of the guard window
    send_vertex(642, 0, 0);
    send_vertex(-560, 0, 0);           // left edge
    send_vertex(-562, 0, 0);
    send_vertex(0, -500, 0);           // bottom edge
    send_vertex(0, -502, 0);
    send_vertex(0, 500, 0);            // top edge
    send_vertex(0, 502, 0);
    send_vertex(-3, -7, 11);

    // Each phase starts from an empty pipeline: that pause is also where
    // the sender waits for every owed projection to come back.
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_pipeline();
      load_setting(phase);
      run_vertices(PHASE_ITEMS, phase < PHASES - CALM_PHASES);
    end

    drain_pipeline();
    repeat (vrp_pkg::LATENCY + 5) @(posedge clk);

    if (projections.mismatches == 0 && projections.outstanding() == 0)
      $display("vertex_rotate_project_test OK");
    else
      $display("vertex_rotate_project_test NOT OK");
    $finish;
  end

endmodule
